>>> hw/rtl/m4cd_pkg.sv
// Shared types and constants of the column decimator.
package m4cd_pkg;

  localparam int RANGE_BITS    = 12;
  localparam int WIDTH_BITS    = 13;
  localparam int TIME_BITS     = 64;
  localparam int NS_BITS       = 30;
  localparam int RANGE_NS_BITS = RANGE_BITS + NS_BITS;
  localparam int COL_BITS      = WIDTH_BITS;
  localparam int OUT_COL_BITS  = 12;
  localparam int KIND_BITS     = 2;
  localparam int CFG_IDX_BITS  = 2;
  localparam int DIV_BITS      = 64;
  localparam int DIV_CNT_BITS  = $clog2(DIV_BITS);

  localparam logic [NS_BITS-1:0] NS_PER_SECOND = 30'd1000000000;

  localparam logic [CFG_IDX_BITS-1:0] REG_RANGE_SECONDS = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PLOT_WIDTH    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LATEST_TIME   = 2'd2;

  localparam logic [RANGE_BITS-1:0] RANGE_SECONDS_RESET = 12'd1;
  localparam logic [WIDTH_BITS-1:0] PLOT_WIDTH_RESET    = 13'd100;
  localparam logic [TIME_BITS-1:0]  LATEST_TIME_RESET   = 64'd0;

  localparam logic [KIND_BITS-1:0] KIND_ENTRY  = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_FIRST  = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_SECOND = 2'd2;
  localparam logic [KIND_BITS-1:0] KIND_EXIT   = 2'd3;

  typedef enum logic [1:0] {
    DIV_NPP  = 2'd0,
    DIV_END  = 2'd1,
    DIV_DIST = 2'd2
  } div_op_t;

  typedef struct packed {
    logic                 accept;
    logic                 div_start;
    div_op_t              div_op;
    logic                 latch_npp;
    logic                 latch_end;
    logic                 latch_start;
    logic                 latch_x;
    logic                 bin;
    logic                 emit;
    logic                 tail;
    logic [KIND_BITS-1:0] kind;
    logic                 close;
  } m4cd_cmd_t;

  typedef struct packed {
    logic grid_dirty;
    logic div_done;
    logic in_window;
    logic flush;
    logic col_open;
    logic out_free;
    logic last;
  } m4cd_status_t;

endpackage

>>> hw/rtl/m4cd_divider.sv
// Serial restoring divider, one quotient bit per cycle.
module m4cd_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [m4cd_pkg::DIV_BITS-1:0] dividend,
  input  logic [m4cd_pkg::DIV_BITS-1:0] divisor,
  output logic [m4cd_pkg::DIV_BITS-1:0] quotient,
  output logic [m4cd_pkg::DIV_BITS-1:0] remainder,
  output logic                          done
);

  localparam int DB = m4cd_pkg::DIV_BITS;

  logic [DB-1:0]                     quo;
  logic [DB-1:0]                     rem;
  logic [DB-1:0]                     dvs;
  logic [m4cd_pkg::DIV_CNT_BITS-1:0] cnt;
  logic                              busy;
  logic [DB:0]                       trial;

  assign trial = {rem, quo[DB-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == m4cd_pkg::DIV_CNT_BITS'(DB - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[DB]) begin
        rem <= trial[DB-1:0];
        quo <= {quo[DB-2:0], 1'b1};
      end else begin
        rem <= {rem[DB-2:0], quo[DB-1]};
        quo <= {quo[DB-2:0], 1'b0};
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

>>> hw/rtl/m4cd_datapath.sv
// Datapath: configuration, pixel grid, column state and output register.
module m4cd_datapath #(
  parameter int MAX_COLUMNS = 4096,
  parameter int VALUE_BITS  = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [m4cd_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [m4cd_pkg::TIME_BITS-1:0]        cfg_data,
  input  logic [m4cd_pkg::TIME_BITS-1:0]        sample_time,
  input  logic signed [VALUE_BITS-1:0]          sample_value,
  input  logic                                  is_last,
  input  logic                                  out_stall,
  output logic                                  out_valid,
  output logic [m4cd_pkg::OUT_COL_BITS-1:0]     column,
  output logic signed [VALUE_BITS-1:0]          point_value,
  output logic [m4cd_pkg::KIND_BITS-1:0]        point_kind,
  output logic                                  end_of_run,
  input  m4cd_pkg::m4cd_cmd_t                   cmd,
  output m4cd_pkg::m4cd_status_t                st
);

  localparam int TB = m4cd_pkg::TIME_BITS;
  localparam int DB = m4cd_pkg::DIV_BITS;
  localparam int RB = m4cd_pkg::RANGE_NS_BITS;
  localparam int WB = m4cd_pkg::WIDTH_BITS;
  localparam int CB = m4cd_pkg::COL_BITS;

  logic [m4cd_pkg::RANGE_BITS-1:0] range_seconds;
  logic [WB-1:0]                   plot_width;
  logic [TB-1:0]                   latest_time;
  logic                            grid_dirty;

  logic [RB-1:0] span_ns_c;
  logic [WB-1:0] w_c;
  logic [RB-1:0] span_ns;
  logic [WB-1:0] w_q;
  logic [RB-1:0] npp;
  logic [TB-1:0] wend;
  logic [TB-1:0] wstart;

  logic [TB-1:0]                  t_q;
  logic signed [VALUE_BITS-1:0]   v_q;
  logic                           last_q;
  logic [CB-1:0]                  x_q;

  logic [CB-1:0]                  open_column;
  logic                           column_open;
  logic signed [VALUE_BITS-1:0]   entry_value;
  logic signed [VALUE_BITS-1:0]   exit_value;
  logic signed [VALUE_BITS-1:0]   min_value;
  logic signed [VALUE_BITS-1:0]   max_value;
  logic [TB-1:0]                  min_time;
  logic [TB-1:0]                  max_time;

  logic [DB-1:0] div_dividend;
  logic [DB-1:0] div_divisor;
  logic [DB-1:0] div_quo;
  logic [DB-1:0] div_rem;
  logic          div_done;

  logic                         new_col;
  logic                         min_first;
  logic signed [VALUE_BITS-1:0] emit_value;

  assign span_ns_c = RB'(range_seconds) * RB'(m4cd_pkg::NS_PER_SECOND);
  assign w_c = (plot_width == '0) ? WB'(1) :
               ((32'(plot_width) > MAX_COLUMNS) ? WB'(MAX_COLUMNS) : plot_width);

  always_ff @(posedge clk) begin
    if (rst) begin
      range_seconds <= m4cd_pkg::RANGE_SECONDS_RESET;
      plot_width    <= m4cd_pkg::PLOT_WIDTH_RESET;
      latest_time   <= m4cd_pkg::LATEST_TIME_RESET;
      grid_dirty    <= 1'b1;
    end else begin
      if (cfg_we) begin
        grid_dirty <= 1'b1;
        unique case (cfg_index)
          m4cd_pkg::REG_RANGE_SECONDS: range_seconds <= cfg_data[m4cd_pkg::RANGE_BITS-1:0];
          m4cd_pkg::REG_PLOT_WIDTH:    plot_width <= cfg_data[WB-1:0];
          m4cd_pkg::REG_LATEST_TIME:   latest_time <= cfg_data;
          default: ;
        endcase
      end else if (cmd.latch_start) begin
        grid_dirty <= 1'b0;
      end
    end
  end

  always_comb begin
    unique case (cmd.div_op)
      m4cd_pkg::DIV_NPP: begin
        div_dividend = DB'(span_ns_c);
        div_divisor  = DB'(w_c);
      end
      m4cd_pkg::DIV_END: begin
        div_dividend = latest_time;
        div_divisor  = DB'(npp);
      end
      m4cd_pkg::DIV_DIST: begin
        div_dividend = wend - t_q;
        div_divisor  = DB'(npp);
      end
      default: begin
        div_dividend = latest_time;
        div_divisor  = DB'(npp);
      end
    endcase
  end

  m4cd_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_quo),
    .remainder (div_rem),
    .done      (div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_start && cmd.div_op == m4cd_pkg::DIV_NPP) begin
      span_ns <= span_ns_c;
      w_q     <= w_c;
    end
    if (cmd.latch_npp) begin
      npp <= (div_quo == '0) ? RB'(1) : div_quo[RB-1:0];
    end
    if (cmd.latch_end) begin
      wend <= latest_time - div_rem;
    end
    if (cmd.latch_start) begin
      wstart <= (wend > TB'(span_ns)) ? (wend - TB'(span_ns)) : '0;
    end
    if (cmd.accept) begin
      t_q    <= sample_time;
      v_q    <= sample_value;
      last_q <= is_last;
    end
    if (cmd.latch_x) begin
      x_q <= (div_quo >= DB'(w_q)) ? '0 : (w_q - CB'(1) - div_quo[CB-1:0]);
    end
  end

  assign new_col = !column_open || (x_q != open_column);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_open <= 1'b0;
    end else if (cmd.bin) begin
      column_open <= 1'b1;
    end else if (cmd.close) begin
      column_open <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bin) begin
      exit_value <= v_q;
      if (new_col) begin
        open_column <= x_q;
        entry_value <= v_q;
        min_value   <= v_q;
        max_value   <= v_q;
        min_time    <= t_q;
        max_time    <= t_q;
      end else begin
        if (v_q < min_value) begin
          min_value <= v_q;
          min_time  <= t_q;
        end
        if (v_q > max_value) begin
          max_value <= v_q;
          max_time  <= t_q;
        end
      end
    end
  end

  assign min_first = (min_time < max_time);

  always_comb begin
    unique case (cmd.kind)
      m4cd_pkg::KIND_ENTRY:  emit_value = entry_value;
      m4cd_pkg::KIND_FIRST:  emit_value = min_first ? min_value : max_value;
      m4cd_pkg::KIND_SECOND: emit_value = min_first ? max_value : min_value;
      m4cd_pkg::KIND_EXIT:   emit_value = exit_value;
      default:               emit_value = exit_value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      column      <= open_column[m4cd_pkg::OUT_COL_BITS-1:0];
      point_value <= emit_value;
      point_kind  <= cmd.kind;
      end_of_run  <= cmd.tail || (cmd.kind == m4cd_pkg::KIND_EXIT && !last_q);
    end
  end

  assign st.grid_dirty = grid_dirty;
  assign st.div_done   = div_done;
  assign st.in_window  = (t_q >= wstart) && (t_q <= wend);
  assign st.flush      = column_open && (x_q != open_column);
  assign st.col_open   = column_open;
  assign st.out_free   = !out_valid || !out_stall;
  assign st.last       = last_q;

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || !out_stall))
    else $error("point loaded over a pending transaction");

  a_bin_grid: assert property (@(posedge clk) disable iff (rst)
    cmd.bin |-> !grid_dirty)
    else $error("sample binned on a stale grid");

  a_npp_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.latch_npp |=> (npp != '0))
    else $error("pixel period is zero");

endmodule

>>> hw/rtl/m4cd_ctrl.sv
// Controller: sequences grid update, column lookup, binning and point output.
module m4cd_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  m4cd_pkg::m4cd_status_t st,
  output m4cd_pkg::m4cd_cmd_t    cmd
);

  typedef enum logic [12:0] {
    S_IDLE      = 13'b0000000000001,
    S_NPP_GO    = 13'b0000000000010,
    S_NPP_WAIT  = 13'b0000000000100,
    S_END_GO    = 13'b0000000001000,
    S_END_WAIT  = 13'b0000000010000,
    S_GRID_FIN  = 13'b0000000100000,
    S_WIN       = 13'b0000001000000,
    S_DIST_GO   = 13'b0000010000000,
    S_DIST_WAIT = 13'b0000100000000,
    S_DECIDE    = 13'b0001000000000,
    S_FLUSH     = 13'b0010000000000,
    S_BIN       = 13'b0100000000000,
    S_TAIL      = 13'b1000000000000
  } state_t;

  state_t                           state;
  state_t                           state_next;
  logic [m4cd_pkg::KIND_BITS-1:0]   k;
  logic [m4cd_pkg::KIND_BITS-1:0]   k_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= m4cd_pkg::KIND_ENTRY;
    end else begin
      state <= state_next;
      k     <= k_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    k_next     = k;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = st.grid_dirty ? S_NPP_GO : S_WIN;
        end
      end
      S_NPP_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = m4cd_pkg::DIV_NPP;
        state_next    = S_NPP_WAIT;
      end
      S_NPP_WAIT: begin
        if (st.div_done) begin
          cmd.latch_npp = 1'b1;
          state_next    = S_END_GO;
        end
      end
      S_END_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = m4cd_pkg::DIV_END;
        state_next    = S_END_WAIT;
      end
      S_END_WAIT: begin
        if (st.div_done) begin
          cmd.latch_end = 1'b1;
          state_next    = S_GRID_FIN;
        end
      end
      S_GRID_FIN: begin
        cmd.latch_start = 1'b1;
        state_next      = S_WIN;
      end
      S_WIN: begin
        if (st.in_window) begin
          state_next = S_DIST_GO;
        end else begin
          state_next = st.last ? S_TAIL : S_IDLE;
        end
      end
      S_DIST_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = m4cd_pkg::DIV_DIST;
        state_next    = S_DIST_WAIT;
      end
      S_DIST_WAIT: begin
        if (st.div_done) begin
          cmd.latch_x = 1'b1;
          state_next  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        k_next     = m4cd_pkg::KIND_ENTRY;
        state_next = st.flush ? S_FLUSH : S_BIN;
      end
      S_FLUSH: begin
        cmd.kind = k;
        if (st.out_free) begin
          cmd.emit = 1'b1;
          k_next   = k + 1'b1;
          if (k == m4cd_pkg::KIND_EXIT) begin
            state_next = S_BIN;
          end
        end
      end
      S_BIN: begin
        cmd.bin    = 1'b1;
        state_next = st.last ? S_TAIL : S_IDLE;
      end
      S_TAIL: begin
        cmd.kind = m4cd_pkg::KIND_EXIT;
        cmd.tail = 1'b1;
        if (!st.col_open) begin
          cmd.close  = 1'b1;
          state_next = S_IDLE;
        end else if (st.out_free) begin
          cmd.emit   = 1'b1;
          cmd.close  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    st.div_done |-> (state == S_NPP_WAIT || state == S_END_WAIT || state == S_DIST_WAIT))
    else $error("divider finished outside a wait state");

endmodule

>>> hw/rtl/m4_column_decimator_core.sv
// Top level of the M4 column decimator.
//
// Samples enter on the in channel (in_valid/in_stall) in time order; each
// transaction carries sample_time, sample_value and is_last. Points leave
// on the out channel (out_valid/out_stall): column, point_value, point_kind
// and end_of_run, which marks the last point that one sample causes.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
//
// A sample inside the window, when the pixel grid is current, needs one
// 64-bit division on the serial divider, one quotient bit per cycle, and
// emits up to five points, paused while the out channel stalls. A sample
// outside the window needs no division. The first sample after a write to
// the configuration rebuilds the grid with two more divisions on the same
// divider. One sample is in work at a time; in_stall is low only while the
// controller is idle.
//
// Reset loads the register defaults and closes the open column. A stall on
// the out channel holds the output register and pauses point emission; the
// next sample is still accepted while the final point of a sample waits.
module m4_column_decimator_core #(
  parameter int MAX_COLUMNS = 4096,
  parameter int VALUE_BITS  = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [m4cd_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [m4cd_pkg::TIME_BITS-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [m4cd_pkg::TIME_BITS-1:0]    sample_time,
  input  logic signed [VALUE_BITS-1:0]      sample_value,
  input  logic                              is_last,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [m4cd_pkg::OUT_COL_BITS-1:0] column,
  output logic signed [VALUE_BITS-1:0]      point_value,
  output logic [m4cd_pkg::KIND_BITS-1:0]    point_kind,
  output logic                              end_of_run
);

  m4cd_pkg::m4cd_cmd_t    cmd;
  m4cd_pkg::m4cd_status_t st;

  m4cd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  m4cd_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_time  (sample_time),
    .sample_value (sample_value),
    .is_last      (is_last),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .column       (column),
    .point_value  (point_value),
    .point_kind   (point_kind),
    .end_of_run   (end_of_run),
    .cmd          (cmd),
    .st           (st)
  );

endmodule

>>> tb/tb.sv
// Self-checking testbench of the M4 column decimator: directed and random samples vs a predictor.
module tb;
  import m4cd_pkg::*;

  localparam int MAX_COLS         = 4096;
  localparam int VAL_W            = 32;
  localparam int SETTLE_CYCLES    = 300;
  localparam int HOLD_CYCLES      = 1500;
  localparam int WATCHDOG_LIMIT   = 10000;
  localparam int RANDOM_PER_GRID  = 8;
  localparam int EXP_DEPTH        = 256;

  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;
  localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [VAL_W-1:0] VAL_MAX = 32'h7fff_ffff;
  localparam logic [TIME_BITS-1:0] TIME_MAX = 64'hffff_ffff_ffff_ffff;

  typedef struct packed {
    logic [OUT_COL_BITS-1:0] column;
    logic [VAL_W-1:0]        value;
    logic [KIND_BITS-1:0]    kind;
    logic                    eor;
  } point_t;

  logic                    clk          = 1'b0;
  logic                    rst          = 1'b1;
  logic                    cfg_we       = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index    = '0;
  logic [TIME_BITS-1:0]    cfg_data     = '0;
  logic                    in_valid     = 1'b0;
  logic                    in_stall;
  logic [TIME_BITS-1:0]    sample_time  = '0;
  logic signed [VAL_W-1:0] sample_value = '0;
  logic                    is_last      = 1'b0;
  logic                    out_valid;
  logic                    out_stall    = 1'b0;
  logic [OUT_COL_BITS-1:0] column;
  logic signed [VAL_W-1:0] point_value;
  logic [KIND_BITS-1:0]    point_kind;
  logic                    end_of_run;

  logic [RANGE_BITS-1:0]   grid_range  = RANGE_SECONDS_RESET;
  logic [WIDTH_BITS-1:0]   grid_width  = PLOT_WIDTH_RESET;
  logic [TIME_BITS-1:0]    grid_latest = LATEST_TIME_RESET;
  logic [OUT_COL_BITS-1:0] cur_col     = '0;
  logic                    col_live    = 1'b0;
  logic [VAL_W-1:0]        first_val   = '0;
  logic [VAL_W-1:0]        last_val    = '0;
  logic [VAL_W-1:0]        lo_val      = '0;
  logic [VAL_W-1:0]        hi_val      = '0;
  logic [TIME_BITS-1:0]    lo_time     = '0;
  logic [TIME_BITS-1:0]    hi_time     = '0;

  point_t exp_points[EXP_DEPTH];
  int     exp_wr = 0;
  int     exp_rd = 0;
  point_t burst[5];
  int     burst_n;

  int errors      = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int hold_reqs   = 0;
  int hold_seen   = 0;
  int hold_left   = 0;
  int idle_cycles = 0;

  m4_column_decimator_core #(
    .MAX_COLUMNS(MAX_COLS),
    .VALUE_BITS (VAL_W)
  ) i_dut (.*);

  initial forever #5 clk = ~clk;

  function automatic logic [63:0] eff_width();
    logic [63:0] w;
    w = grid_width;
    if (w < 1) w = 1;
    if (w > MAX_COLS) w = MAX_COLS;
    return w;
  endfunction

  function automatic logic [63:0] span_ns();
    logic [63:0] r;
    r = grid_range;
    return r * NS_PER_SECOND;
  endfunction

  function automatic logic [63:0] pixel_ns();
    logic [63:0] npp;
    npp = span_ns() / eff_width();
    if (npp == 0) npp = 1;
    return npp;
  endfunction

  function automatic logic [63:0] grid_end();
    return (grid_latest / pixel_ns()) * pixel_ns();
  endfunction

  function automatic logic [63:0] grid_start();
    logic [63:0] e;
    e = grid_end();
    return (e > span_ns()) ? e - span_ns() : 64'd0;
  endfunction

  function automatic logic in_window(input logic [63:0] t);
    return (t >= grid_start()) && (t <= grid_end());
  endfunction

  function automatic void add_point(input logic [OUT_COL_BITS-1:0] col,
                                    input logic [VAL_W-1:0] val,
                                    input logic [KIND_BITS-1:0] kind);
    burst[burst_n] = {col, val, kind, 1'b0};
    burst_n++;
  endfunction

  function automatic void bin_sample(input logic [63:0] t, input logic [VAL_W-1:0] v,
                                     input logic last);
    logic [63:0] w;
    logic [63:0] npp;
    logic [63:0] d;
    logic [63:0] xw;
    logic [OUT_COL_BITS-1:0] x;
    point_t p;
    w = eff_width();
    npp = pixel_ns();
    burst_n = 0;
    if (in_window(t)) begin
      d = (grid_end() - t) / npp;
      xw = (d >= w) ? 64'd0 : w - 1 - d;
      x = xw[OUT_COL_BITS-1:0];
      if (!col_live || x != cur_col) begin
        if (col_live) begin
          add_point(cur_col, first_val, KIND_ENTRY);
          if (lo_time < hi_time) begin
            add_point(cur_col, lo_val, KIND_FIRST);
            add_point(cur_col, hi_val, KIND_SECOND);
          end else begin
            add_point(cur_col, hi_val, KIND_FIRST);
            add_point(cur_col, lo_val, KIND_SECOND);
          end
          add_point(cur_col, last_val, KIND_EXIT);
        end
        cur_col = x;
        col_live = 1'b1;
        first_val = v;
        last_val = v;
        lo_val = v;
        hi_val = v;
        lo_time = t;
        hi_time = t;
      end else begin
        last_val = v;
        if ($signed(v) < $signed(lo_val)) begin
          lo_val = v;
          lo_time = t;
        end
        if ($signed(hi_val) < $signed(v)) begin
          hi_val = v;
          hi_time = t;
        end
      end
    end
    if (last) begin
      if (col_live) add_point(cur_col, last_val, KIND_EXIT);
      col_live = 1'b0;
    end
    if (burst_n > 0) begin
      p = burst[burst_n-1];
      p.eor = 1'b1;
      burst[burst_n-1] = p;
    end
    for (int i = 0; i < burst_n; i++) begin
      exp_points[exp_wr % EXP_DEPTH] = burst[i];
      exp_wr++;
    end
  endfunction

  function automatic void note_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(7))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [63:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_RANGE_SECONDS: grid_range = data[RANGE_BITS-1:0];
      REG_PLOT_WIDTH:    grid_width = data[WIDTH_BITS-1:0];
      REG_LATEST_TIME:   grid_latest = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_sample(input logic [63:0] t, input logic [VAL_W-1:0] v,
                             input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_time <= t;
    sample_value <= v;
    is_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bin_sample(t, v, last);
  endtask

  // drop valid, wait for every expected point, then let the block finish skipped samples
  task automatic drain();
    in_valid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_grid(input logic [63:0] r, input logic [63:0] w, input logic [63:0] l);
    write_reg(REG_RANGE_SECONDS, r);
    write_reg(REG_PLOT_WIDTH, w);
    write_reg(REG_LATEST_TIME, l);
  endtask

  task automatic test_reset_grid();
    idle_pct = 30;
    stall_pct <= 30;
    send_sample(64'd0, VAL_MAX, 1'b0);
    send_sample(64'd0, VAL_MIN, 1'b0);
    send_sample(64'd0, 32'd5, 1'b1);
    send_sample(64'd7, 32'd9, 1'b1);
  endtask

  task automatic test_extreme_order();
    drain();
    set_grid(64'd1, 64'd100, 64'd1_000_000_123);
    send_sample(64'd0, 32'd0, 1'b0);
    send_sample(64'd5_000_000, VAL_MIN, 1'b0);
    send_sample(64'd6_000_000, VAL_MAX, 1'b0);
    send_sample(64'd15_000_000, 32'd10, 1'b0);
    send_sample(64'd16_000_000, 32'd20, 1'b0);
    send_sample(64'd17_000_000, -32'sd5, 1'b0);
    send_sample(64'd35_000_000, 32'd7, 1'b0);
    send_sample(64'd35_000_000, 32'd7, 1'b0);
    send_sample(64'd1_000_000_000, 32'd3, 1'b0);
    send_sample(64'd1_000_000_001, 32'd9, 1'b0);
    send_sample(64'd1_000_000_000, 32'd1, 1'b1);
  endtask

  task automatic test_last_sample();
    send_sample(64'd300_000_000, 32'd42, 1'b1);
    send_sample(64'd100_000_000, 32'd1, 1'b0);
    send_sample(64'd200_000_000, 32'd2, 1'b1);
    send_sample(64'd2_000_000_000, 32'd5, 1'b1);
  endtask

  task automatic test_width_clamp();
    logic [63:0] s;
    logic [63:0] e;
    logic [63:0] npp;
    drain();
    set_grid(64'd1, 64'd0, 64'd1_000_000_000);
    send_sample(64'd0, 32'hffff_ffff, 1'b0);
    send_sample(64'd1_000_000_000, 32'd1, 1'b1);
    drain();
    write_reg(REG_UNUSED, {$urandom, $urandom});
    set_grid(64'hfff, 64'h1fff, TIME_MAX);
    s = grid_start();
    e = grid_end();
    npp = pixel_ns();
    send_sample(s - 1, 32'd1, 1'b0);
    send_sample(s, VAL_MIN, 1'b0);
    send_sample(e - npp * 4095, VAL_MAX, 1'b0);
    send_sample(e, 32'h1234_5678, 1'b0);
    send_sample(TIME_MAX, 32'hdead_beef, 1'b1);
  endtask

  task automatic test_zero_range();
    drain();
    set_grid(64'd0, 64'd100, 64'd12345);
    send_sample(64'd12344, 32'd1, 1'b0);
    send_sample(64'd12345, 32'd2, 1'b1);
  endtask

  task automatic test_backpressure();
    drain();
    set_grid(64'd1, 64'd100, 64'd1_000_000_000);
    idle_pct = 0;
    stall_pct <= 0;
    hold_reqs <= hold_reqs + 1;
    for (int k = 0; k < 8; k++)
      send_sample(64'd5_000_000 + 64'd10_000_000 * k, rand_value(), k == 7);
  endtask

  task automatic random_grid();
    logic [63:0] junk;
    logic [RANGE_BITS-1:0] r;
    logic [WIDTH_BITS-1:0] w;
    case ($urandom_range(5))
      0: r = 12'd1;
      1: r = 12'd3600;
      2: r = 12'hfff;
      default: r = $urandom_range(1, 3600);
    endcase
    case ($urandom_range(7))
      0: w = 13'd0;
      1: w = 13'd1;
      2: w = 13'd4096;
      3: w = 13'h1fff;
      default: w = $urandom_range(2, 300);
    endcase
    junk = {$urandom, $urandom};
    write_reg(REG_RANGE_SECONDS, {junk[63:RANGE_BITS], r});
    junk = {$urandom, $urandom};
    write_reg(REG_PLOT_WIDTH, {junk[63:WIDTH_BITS], w});
    if ($urandom_range(3) == 0)
      write_reg(REG_LATEST_TIME, pixel_ns() * $urandom_range(1, 50) + $urandom_range(0, 999));
    else
      write_reg(REG_LATEST_TIME, {$urandom, $urandom});
  endtask

  task automatic random_pass(inout int counted);
    logic [63:0] t;
    logic [63:0] ts;
    logic [63:0] npp;
    logic [63:0] step;
    logic noise;
    logic last;
    int n;
    npp = pixel_ns();
    n = $urandom_range(2, 10);
    t = grid_start() + (npp / 4) * $urandom_range(0, 3) + $urandom_range(0, 99);
    for (int i = 0; i < n; i++) begin
      noise = ($urandom_range(9) == 0);
      ts = noise ? {$urandom, $urandom} : t;
      last = (i == n - 1) || (noise && $urandom_range(1));
      if (in_window(ts)) counted++;
      send_sample(ts, rand_value(), last);
      step = (npp / 2) * $urandom_range(0, 3) + $urandom_range(0, 2);
      t = (t > ~step) ? TIME_MAX : t + step;
    end
  endtask

  task automatic test_random_phase(input int idle, input int stall);
    int counted;
    for (int k = 0; k < 2; k++) begin
      drain();
      idle_pct = idle;
      stall_pct <= stall;
      random_grid();
      counted = 0;
      while (counted < RANDOM_PER_GRID) random_pass(counted);
    end
  endtask

  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : check_points
    point_t want;
    if (!rst && out_valid && !out_stall) begin
      if (exp_wr == exp_rd) begin
        note_error($sformatf("unexpected point: column %0d kind %0d value %h end %b",
                             column, point_kind, point_value, end_of_run));
      end else begin
        want = exp_points[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (column !== want.column || point_value !== want.value ||
            point_kind !== want.kind || end_of_run !== want.eor)
          note_error($sformatf({"point mismatch: got column %0d kind %0d value %h end %b, ",
                                "expected column %0d kind %0d value %h end %b"},
                               column, point_kind, point_value, end_of_run,
                               want.column, want.kind, want.value, want.eor));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles < WATCHDOG_LIMIT) begin
      idle_cycles <= idle_cycles + 1;
    end else begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_grid();
    test_extreme_order();
    test_last_sample();
    test_width_clamp();
    test_zero_range();
    test_backpressure();
    test_random_phase(0, 0);
    test_random_phase(61, 0);
    test_random_phase(0, 61);
    test_random_phase(18, 18);
    drain();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
